// ----- rtl/core/rbsi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray versus box slab test pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_W      = 32;
  // divider: input, magnitude, setup, one stage per quotient bit, sign fixup
  localparam int DIV_LAT   = FX_W + 4;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};

  typedef struct packed {
    fx_t [2:0]  org;
    fx_t [2:0]  dir;
    logic [2:0] dzero;
    logic       miss;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/core/rbsi_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined fixed point slab divider: ((corner - origin) << FRAC_BITS) / den,
// truncated toward zero and saturated, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div import rbsi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire fx_t  corner,
  input  wire fx_t  origin,
  input  wire fx_t  den,
  output fx_t       quot
);

  localparam int HI_W = FRAC_BITS + 1;

  logic signed [FX_W:0] diff0;
  fx_t                  den0;
  logic                 neg1;
  logic [FX_W:0]        nmag1;
  logic [FX_W-1:0]      dmag1;

  logic [FX_W-1:0] rem_s  [0:FX_W];
  logic [FX_W-1:0] low_s  [0:FX_W];
  logic [FX_W-1:0] q_s    [0:FX_W];
  logic [FX_W-1:0] d_s    [0:FX_W];
  logic            neg_s  [0:FX_W];
  logic            ovf_s  [0:FX_W];

  logic [HI_W-1:0] hi1;
  logic [FX_W-1:0] quot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff0 <= '0;
    end else if (en) begin
      diff0 <= (FX_W+1)'(corner) - (FX_W+1)'(origin);
      den0  <= den;
    end
  end

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= diff0[FX_W] ^ den0[FX_W-1];
      nmag1 <= diff0[FX_W] ? (FX_W+1)'(-diff0) : (FX_W+1)'(diff0);
      dmag1 <= den0[FX_W-1] ? FX_W'(-den0) : FX_W'(den0);
    end
  end

  // upper part of the scaled numerator decides overflow and seeds the remainder
  assign hi1 = nmag1[FX_W:FX_W-FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s[0] <= FX_W'(hi1) >= dmag1;
      rem_s[0] <= FX_W'(hi1);
      low_s[0] <= {nmag1[FX_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      q_s[0]   <= '0;
      d_s[0]   <= dmag1;
      neg_s[0] <= neg1;
    end
  end

  for (genvar k = 0; k < FX_W; k++) begin : g_bit
    logic [FX_W:0] trial;
    logic          take;
    assign trial = {rem_s[k], low_s[k][FX_W-1]};
    assign take  = trial >= {1'b0, d_s[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= take ? FX_W'(trial - {1'b0, d_s[k]}) : trial[FX_W-1:0];
        low_s[k+1] <= {low_s[k][FX_W-2:0], 1'b0};
        q_s[k+1]   <= {q_s[k][FX_W-2:0], take};
        d_s[k+1]   <= d_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  always_comb begin
    if (neg_s[FX_W]) begin
      if (ovf_s[FX_W] || q_s[FX_W] > FX_MIN) quot_next = FX_MIN;
      else                                    quot_next = -q_s[FX_W];
    end else begin
      if (ovf_s[FX_W] || q_s[FX_W][FX_W-1]) quot_next = FX_MAX;
      else                                   quot_next = q_s[FX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= quot_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ray_box_slab_intersect_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray against axis-aligned box slab test in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One beat in, one beat out, fully pipelined: a new ray/box beat is taken
// every cycle unless the output is stalled. Most of the pipeline is the six
// parallel slab dividers, which resolve one quotient bit per stage. When the
// output is stalled the whole pipeline holds, and in_ready follows out_ready
// while a result is waiting.
module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire fx_t  origin_x,
  input  wire fx_t  origin_y,
  input  wire fx_t  origin_z,
  input  wire fx_t  direction_x,
  input  wire fx_t  direction_y,
  input  wire fx_t  direction_z,
  input  wire fx_t  box_min_x,
  input  wire fx_t  box_min_y,
  input  wire fx_t  box_min_z,
  input  wire fx_t  box_max_x,
  input  wire fx_t  box_max_y,
  input  wire fx_t  box_max_z,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      hit_flag,
  output fx_t       distance,
  output fx_t       hit_x,
  output fx_t       hit_y,
  output fx_t       hit_z
);

  logic en;
  fx_t  org_in [3];
  fx_t  dir_in [3];
  fx_t  bmin_in [3];
  fx_t  bmax_in [3];
  fx_t  qa [3];
  fx_t  qb [3];
  side_t side_in;

  side_t              side_s [0:DIV_LAT-1];
  logic [DIV_LAT-1:0] vld_s;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign org_in  = '{origin_x, origin_y, origin_z};
  assign dir_in  = '{direction_x, direction_y, direction_z};
  assign bmin_in = '{box_min_x, box_min_y, box_min_z};
  assign bmax_in = '{box_max_x, box_max_y, box_max_z};

  // zero direction: the origin must sit inside the slab
  always_comb begin
    fx_t lo;
    fx_t hi;
    side_in = '0;
    for (int a = 0; a < 3; a++) begin
      lo = (bmin_in[a] < bmax_in[a]) ? bmin_in[a] : bmax_in[a];
      hi = (bmin_in[a] < bmax_in[a]) ? bmax_in[a] : bmin_in[a];
      side_in.org[a]   = org_in[a];
      side_in.dir[a]   = dir_in[a];
      side_in.dzero[a] = dir_in[a] == '0;
      if (side_in.dzero[a] && (org_in[a] < lo || org_in[a] > hi)) side_in.miss = 1'b1;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div u_div_min (
      .clk(clk), .rst(rst), .en(en),
      .corner(bmin_in[a]), .origin(org_in[a]), .den(dir_in[a]), .quot(qa[a])
    );
    rbsi_div u_div_max (
      .clk(clk), .rst(rst), .en(en),
      .corner(bmax_in[a]), .origin(org_in[a]), .den(dir_in[a]), .quot(qb[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= '0;
    end else if (en) begin
      vld_s <= {vld_s[DIV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_s[0] <= side_in;
      for (int i = 1; i < DIV_LAT; i++) side_s[i] <= side_s[i-1];
    end
  end

  // narrow the slabs
  side_t p1_side;
  logic  p1_valid;
  fx_t   p1_tmin;
  fx_t   p1_tmax;
  fx_t   tmin_next;
  fx_t   tmax_next;

  always_comb begin
    fx_t nr;
    fx_t fr;
    tmin_next = FX_MIN;
    tmax_next = FX_MAX;
    for (int a = 0; a < 3; a++) begin
      nr = (qa[a] < qb[a]) ? qa[a] : qb[a];
      fr = (qa[a] < qb[a]) ? qb[a] : qa[a];
      if (!side_s[DIV_LAT-1].dzero[a]) begin
        if (nr > tmin_next) tmin_next = nr;
        if (fr < tmax_next) tmax_next = fr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= vld_s[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side <= side_s[DIV_LAT-1];
      p1_tmin <= tmin_next;
      p1_tmax <= tmax_next;
    end
  end

  // hit decision and hit point products
  logic                  p2_valid;
  logic                  p2_hit;
  fx_t                   p2_tmin;
  fx_t                   p2_tmax;
  fx_t                   p2_org [3];
  logic signed [63:0]    p2_prod [3];
  fx_t                   floor0;

  assign floor0 = (p1_tmin > 0) ? p1_tmin : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_hit  <= !p1_side.miss && (p1_tmax >= floor0);
      p2_tmin <= p1_tmin;
      p2_tmax <= p1_tmax;
      for (int a = 0; a < 3; a++) begin
        p2_org[a]  <= $signed(p1_side.org[a]);
        p2_prod[a] <= 64'(p1_tmin) * 64'($signed(p1_side.dir[a]));
      end
    end
  end

  // shift down, add origin, saturate
  fx_t hit_next [3];

  always_comb begin
    logic signed [63:0] s;
    for (int a = 0; a < 3; a++) begin
      s = (p2_prod[a] >>> FRAC_BITS) + 64'(p2_org[a]);
      if (s < 64'(FX_MIN))      hit_next[a] = FX_MIN;
      else if (s > 64'(FX_MAX)) hit_next[a] = FX_MAX;
      else                      hit_next[a] = s[FX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_flag <= p2_hit;
      distance <= p2_tmin;
      hit_x    <= hit_next[0];
      hit_y    <= hit_next[1];
      hit_z    <= hit_next[2];
    end
  end

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    p2_valid && p2_hit |-> p2_tmax >= p2_tmin)
    else $error("hit with exit before entry");

  a_hit_ahead: assert property (@(posedge clk) disable iff (rst)
    p2_valid && p2_hit |-> p2_tmax >= 0)
    else $error("hit with exit behind origin");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(hit_flag))
    else $error("stalled result beat changed");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    p2_valid && !en |=> p2_valid)
    else $error("pipeline beat lost during stall");

endmodule
`default_nettype wire

// ----- tb/ray_box_slab_intersect_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit_checker
// Watches both channels of the slab test unit, works out the expected result
// of every accepted ray/box beat and compares it with the output beats.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit_checker import rbsi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire fx_t  origin_x,
  input  wire fx_t  origin_y,
  input  wire fx_t  origin_z,
  input  wire fx_t  direction_x,
  input  wire fx_t  direction_y,
  input  wire fx_t  direction_z,
  input  wire fx_t  box_min_x,
  input  wire fx_t  box_min_y,
  input  wire fx_t  box_min_z,
  input  wire fx_t  box_max_x,
  input  wire fx_t  box_max_y,
  input  wire fx_t  box_max_z,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic hit_flag,
  input  wire fx_t  distance,
  input  wire fx_t  hit_x,
  input  wire fx_t  hit_y,
  input  wire fx_t  hit_z,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic hit;
    fx_t  tmin;
    fx_t  px;
    fx_t  py;
    fx_t  pz;
  } hit_result_t;

  hit_result_t hits_due[$];

  function automatic longint clamp32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic longint slab_t(longint num, longint den);
    longint q;
    q = (num * (64'sd1 <<< FRAC_BITS)) / den;
    return clamp32(q);
  endfunction

  function automatic hit_result_t slab_test(fx_t o[3], fx_t d[3], fx_t lo_c[3], fx_t hi_c[3]);
    hit_result_t r;
    longint tn, tf, t1, t2, lo, hi, prod, sh;
    bit miss;
    tn = -64'sd2147483648;
    tf = 64'sd2147483647;
    miss = 0;
    for (int a = 0; a < 3; a++) begin
      if (d[a] == 0) begin
        lo = (lo_c[a] < hi_c[a]) ? lo_c[a] : hi_c[a];
        hi = (lo_c[a] < hi_c[a]) ? hi_c[a] : lo_c[a];
        if (longint'(o[a]) < lo || longint'(o[a]) > hi) miss = 1;
      end else begin
        t1 = slab_t(longint'(lo_c[a]) - longint'(o[a]), longint'(d[a]));
        t2 = slab_t(longint'(hi_c[a]) - longint'(o[a]), longint'(d[a]));
        if (t2 < t1) begin
          lo = t2; hi = t1;
        end else begin
          lo = t1; hi = t2;
        end
        if (lo > tn) tn = lo;
        if (hi < tf) tf = hi;
      end
    end
    r.hit = !miss && (tf >= ((tn > 0) ? tn : 0));
    r.tmin = fx_t'(tn);
    for (int a = 0; a < 3; a++) begin
      prod = tn * longint'(d[a]);
      sh = prod >>> FRAC_BITS;
      sh = clamp32(sh + longint'(o[a]));
      if (a == 0) r.px = fx_t'(sh);
      else if (a == 1) r.py = fx_t'(sh);
      else r.pz = fx_t'(sh);
    end
    return r;
  endfunction

  assign pending = hits_due.size();

  always @(posedge clk) begin
    hit_result_t want, got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        hits_due.push_back(slab_test('{origin_x, origin_y, origin_z},
          '{direction_x, direction_y, direction_z}, '{box_min_x, box_min_y, box_min_z},
          '{box_max_x, box_max_y, box_max_z}));
      if (out_valid && out_ready) begin
        got = '{hit_flag, distance, hit_x, hit_y, hit_z};
        if (hits_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat %p", got);
        end else begin
          want = hits_due.pop_front();
          if (want !== got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

endmodule

// ----- tb/ray_box_slab_intersect_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit_test
// Drives directed and random ray/box beats with random gaps and output
// stalls; the checker predicts each result and the top gives the verdict.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit_test;
  import rbsi_pkg::*;

  localparam int RAND_RAYS = 1130;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  fx_t  ray_in [12];
  logic in_ready, out_valid, hit_flag;
  fx_t  distance, hit_x, hit_y, hit_z;
  int   fail_count, pending, idle_cycles;
  bit   stim_done = 0;

  always #2 clk = ~clk;

  ray_box_slab_intersect_unit dut (
    .clk, .rst, .in_valid, .in_ready,
    .origin_x(ray_in[0]), .origin_y(ray_in[1]), .origin_z(ray_in[2]),
    .direction_x(ray_in[3]), .direction_y(ray_in[4]), .direction_z(ray_in[5]),
    .box_min_x(ray_in[6]), .box_min_y(ray_in[7]), .box_min_z(ray_in[8]),
    .box_max_x(ray_in[9]), .box_max_y(ray_in[10]), .box_max_z(ray_in[11]),
    .out_valid, .out_ready, .hit_flag, .distance, .hit_x, .hit_y, .hit_z
  );

  ray_box_slab_intersect_unit_checker checker_i (
    .clk, .rst, .in_valid, .in_ready,
    .origin_x(ray_in[0]), .origin_y(ray_in[1]), .origin_z(ray_in[2]),
    .direction_x(ray_in[3]), .direction_y(ray_in[4]), .direction_z(ray_in[5]),
    .box_min_x(ray_in[6]), .box_min_y(ray_in[7]), .box_min_z(ray_in[8]),
    .box_max_x(ray_in[9]), .box_max_y(ray_in[10]), .box_max_z(ray_in[11]),
    .out_valid, .out_ready, .hit_flag, .distance, .hit_x, .hit_y, .hit_z,
    .fail_count, .pending
  );

  initial for (int i = 0; i < 12; i++) ray_in[i] = '0;

  // random value, weighted toward small magnitudes and edge codes
  function automatic fx_t pick_coord();
    case ($urandom_range(0, 9))
      0: return FX_MIN;
      1: return FX_MAX;
      2: return '0;
      3, 4: return fx_t'($urandom);
      5: return fx_t'($urandom_range(0, 3)) - 1;
      default: return fx_t'(int'($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000);
    endcase
  endfunction

  task automatic send_ray(fx_t v[12]);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    ray_in = v;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_ray();
    fx_t v[12];
    for (int i = 0; i < 12; i++) v[i] = pick_coord();
    // mostly a box around a point near the ray origin
    if ($urandom_range(0, 3) != 0)
      for (int a = 0; a < 3; a++) begin
        v[6 + a] = v[a] + fx_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0002_0000);
        v[9 + a] = v[6 + a] + fx_t'($urandom_range(0, 32'h0004_0000));
        if ($urandom_range(0, 7) == 0) v[3 + a] = '0;
        else if ($urandom_range(0, 1))
          v[3 + a] = fx_t'(int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      end
    send_ray(v);
  endtask

  initial begin
    fx_t u = 32'sh0001_0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // simple hit, behind origin, swapped corners
    send_ray('{0, 0, 0, u, u, u, u, u, u, 2*u, 2*u, 2*u});
    send_ray('{5*u, 5*u, 5*u, u, u, u, u, u, u, 2*u, 2*u, 2*u});
    send_ray('{0, 0, 0, u, u, u, 2*u, 2*u, 2*u, u, u, u});
    // zero direction with origin inside, outside, all zero, on the bound
    send_ray('{0, 0, 0, 0, u, u, -u, u, u, u, 2*u, 2*u});
    send_ray('{3*u, 0, 0, 0, u, u, -u, u, u, u, 2*u, 2*u});
    send_ray('{0, 0, 0, 0, 0, 0, -u, -u, -u, u, u, u});
    send_ray('{u, u, u, 0, 0, 0, -u, -u, -u, u, u, u});
    send_ray('{u, 0, 0, 0, 0, 0, -u, -u, -u, u, u, u});
    // extremes and saturation
    send_ray('{FX_MIN, FX_MIN, FX_MIN, 1, 1, 1, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX});
    send_ray('{FX_MAX, FX_MAX, FX_MAX, -1, -1, -1, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN});
    send_ray('{FX_MAX, FX_MIN, 0, FX_MIN, FX_MAX, FX_MIN, FX_MIN, FX_MAX, FX_MIN, FX_MAX, FX_MIN, FX_MAX});
    send_ray('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
    send_ray('{0, 0, 0, -u, -u, -u, -2*u, -2*u, -2*u, -u, -u, -u});
    send_ray('{0, 0, 0, u, 3, -7, u, -u, -u, 4*u, u, u});
    repeat (RAND_RAYS) send_random_ray();
    in_valid <= 0;
    stim_done = 1;
  end

  // per result beat: wait a random number of cycles, then take it
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ray_box_slab_intersect_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ray_box_slab_intersect_unit_test OK");
    end else begin
      $display("ray_box_slab_intersect_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rbsi_pkg.sv
rtl/core/rbsi_div.sv
rtl/core/ray_box_slab_intersect_unit.sv
tb/ray_box_slab_intersect_unit_checker.sv
tb/ray_box_slab_intersect_unit_test.sv
